>>> sv/short_touch_sequence_dropper_top_assert.svh
// Assertion macros for the short touch sequence dropper top level.
`ifndef SHORT_TOUCH_SEQUENCE_DROPPER_TOP_ASSERT_SVH
`define SHORT_TOUCH_SEQUENCE_DROPPER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define STSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define STSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/stsd_pkg.sv
// Shared types and constants of the short touch sequence dropper.
package stsd_pkg;

  localparam int SLOT_W    = 4;
  localparam int COORD_W   = 16;
  localparam int CNT_W     = 6;
  localparam int RUN_LEN_W = 6;
  localparam int MAX_RUN   = 32;
  localparam int SLOTS_DEF = 16;
  localparam int DEPTH_DEF = 32;

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [RUN_LEN_W-1:0] RUN_LEN_RESET = RUN_LEN_W'(5);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic        [COORD_W-1:0] p;
  } sample_t;

  typedef enum logic {
    CMD_PASS,
    CMD_RUN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [SLOT_W-1:0] slot;
    sample_t           smp;
    logic [CNT_W-1:0]  cnt;
  } cmd_t;

  typedef struct packed {
    logic             hold;
    logic [CNT_W-1:0] cnt;
  } slot_state_t;

  typedef struct packed {
    logic run_done;
    logic run_active;
  } bk_status_t;

  typedef enum logic {
    FR_IDLE,
    FR_DECIDE
  } fr_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_OUT
  } bk_state_t;

  // slot index width, at least one bit
  function automatic int slot_aw(input int slots);
    return (slots > 1) ? $clog2(slots) : 1;
  endfunction

endpackage

>>> sv/stsd_front.sv
// Front part: accepts samples, looks up per-slot state and decides what to do.
module stsd_front #(
  parameter int SLOTS = stsd_pkg::SLOTS_DEF,
  parameter int DEPTH = stsd_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  valid,
  output logic                                  stall,
  input  logic [stsd_pkg::SLOT_W-1:0]           slot,
  input  logic signed [stsd_pkg::COORD_W-1:0]   pos_x,
  input  logic signed [stsd_pkg::COORD_W-1:0]   pos_y,
  input  logic [stsd_pkg::COORD_W-1:0]          pressure,
  input  logic [stsd_pkg::RUN_LEN_W-1:0]        run_length,
  output logic                                  push,
  output stsd_pkg::cmd_t                        push_cmd,
  input  logic                                  q_full,
  input  stsd_pkg::bk_status_t                  bk_status,
  output logic                                  held_we,
  output logic [stsd_pkg::slot_aw(SLOTS)+$clog2(DEPTH)-1:0] held_waddr,
  output stsd_pkg::sample_t                     held_wdata
);
  import stsd_pkg::*;

  localparam int SAW = slot_aw(SLOTS);
  localparam int DW  = $clog2(DEPTH);
  localparam int LIM = (DEPTH < MAX_RUN) ? DEPTH : MAX_RUN;
  localparam int RPW = $clog2(QDEPTH + 2);

  fr_state_t state, state_next;

  logic                  accept;
  logic                  slot_ok;
  logic [SAW+SLOT_W-1:0] in_wide;
  logic [SAW-1:0]        in_idx;

  // latched request
  logic [SLOT_W-1:0] s_slot;
  logic [SAW-1:0]    s_idx;
  sample_t           s_smp;

  // per-slot state store, registered read, valid bits stand for reset
  slot_state_t st_mem [SLOTS];
  logic [SLOTS-1:0] st_vld;
  slot_state_t st_rd;
  logic        st_rd_vld;
  slot_state_t st_new;
  logic        st_we;

  logic [RPW-1:0] runs_pending;

  // decision signals
  logic                   cur_hold;
  logic [CNT_W-1:0]       cur_cnt;
  logic [CNT_W-1:0]       thr;
  logic [CNT_W-1:0]       cnt_cl;
  logic [CNT_W-1:0]       n_cnt;
  logic [DW+CNT_W-1:0]    cnt_wide;
  logic                   is_up;
  logic                   drop;
  logic                   hold_wr;
  logic                   fire;
  logic                   need_push;
  logic                   go;

  assign in_wide = {{SAW{1'b0}}, slot};
  assign in_idx  = in_wide[SAW-1:0];
  assign slot_ok = (32'(slot) < SLOTS);
  assign accept  = valid && !stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture request and read slot state
  always_ff @(posedge clk) begin
    if (accept && slot_ok) begin
      s_slot    <= slot;
      s_idx     <= in_idx;
      s_smp     <= '{x: pos_x, y: pos_y, p: pressure};
      st_rd     <= st_mem[in_idx];
      st_rd_vld <= st_vld[in_idx];
    end
  end

  // slot state write
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[s_idx] <= st_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
    end else if (st_we) begin
      st_vld[s_idx] <= 1'b1;
    end
  end

  // runs queued or draining in the back part
  always_ff @(posedge clk) begin
    if (rst) begin
      runs_pending <= '0;
    end else begin
      runs_pending <= runs_pending
                    + RPW'(push && (push_cmd.kind == CMD_RUN))
                    - RPW'(bk_status.run_done);
    end
  end

  // effective threshold: run_length saturated to 1..LIM
  always_comb begin
    if (run_length == '0) begin
      thr = CNT_W'(1);
    end else if (32'(run_length) > LIM) begin
      thr = CNT_W'(LIM);
    end else begin
      thr = run_length;
    end
  end

  // decision on the latched sample
  always_comb begin
    cur_hold  = st_rd_vld ? st_rd.hold : 1'b1;
    cur_cnt   = st_rd_vld ? st_rd.cnt  : '0;
    is_up     = (s_smp.p == '0);
    drop      = cur_hold && is_up && (cur_cnt < thr);
    hold_wr   = cur_hold && !drop;
    cnt_cl    = (32'(cur_cnt) >= DEPTH) ? CNT_W'(DEPTH - 1) : cur_cnt;
    n_cnt     = cnt_cl + CNT_W'(1);
    cnt_wide  = {{DW{1'b0}}, cnt_cl};
    fire      = hold_wr && (n_cnt >= thr);
    need_push = !cur_hold || fire;
    go        = !(need_push && q_full) && !(hold_wr && (runs_pending != '0));

    // new slot state
    if (!cur_hold) begin
      st_new = '{hold: is_up, cnt: cur_cnt};
    end else if (drop) begin
      st_new = '{hold: 1'b1, cnt: '0};
    end else if (fire) begin
      st_new = '{hold: 1'b0, cnt: '0};
    end else begin
      st_new = '{hold: 1'b1, cnt: n_cnt};
    end

    push_cmd.kind = cur_hold ? CMD_RUN : CMD_PASS;
    push_cmd.slot = s_slot;
    push_cmd.smp  = s_smp;
    push_cmd.cnt  = n_cnt;

    held_waddr = {s_idx, cnt_wide[DW-1:0]};
    held_wdata = s_smp;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (accept && slot_ok) begin
          state_next = FR_DECIDE;
        end
      end
      FR_DECIDE: begin
        if (go) begin
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    stall   = 1'b1;
    st_we   = 1'b0;
    push    = 1'b0;
    held_we = 1'b0;
    unique case (state)
      FR_IDLE: begin
        stall = 1'b0;
      end
      FR_DECIDE: begin
        st_we   = go;
        push    = go && need_push;
        held_we = go && hold_wr;
      end
      default: stall = 1'b1;
    endcase
  end

endmodule

>>> sv/stsd_queue.sv
// Short command queue between the front and back parts.
module stsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  stsd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output stsd_pkg::cmd_t head,
  output logic           empty
);
  import stsd_pkg::*;

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW + 1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + (QAW + 1)'(push) - (QAW + 1)'(pop);
    end
  end

endmodule

>>> sv/stsd_back.sv
// Back part: holds the sample store and emits pass-through samples and runs.
module stsd_back #(
  parameter int SLOTS = stsd_pkg::SLOTS_DEF,
  parameter int DEPTH = stsd_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_empty,
  input  stsd_pkg::cmd_t                        head,
  output logic                                  pop,
  input  logic                                  held_we,
  input  logic [stsd_pkg::slot_aw(SLOTS)+$clog2(DEPTH)-1:0] held_waddr,
  input  stsd_pkg::sample_t                     held_wdata,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [stsd_pkg::SLOT_W-1:0]           out_slot,
  output logic signed [stsd_pkg::COORD_W-1:0]   out_x,
  output logic signed [stsd_pkg::COORD_W-1:0]   out_y,
  output logic [stsd_pkg::COORD_W-1:0]          out_pressure,
  output logic                                  run_last,
  output stsd_pkg::bk_status_t                  bk_status
);
  import stsd_pkg::*;

  localparam int SAW = slot_aw(SLOTS);
  localparam int DW  = $clog2(DEPTH);
  localparam int AW  = SAW + DW;

  bk_state_t state, state_next;

  // held samples, one row of DEPTH entries per slot
  sample_t held_mem [2**AW];
  sample_t rd_data;
  logic    rd_en;
  logic [AW-1:0] rd_addr;

  // current command
  cmd_kind_t         cur_kind;
  logic [SLOT_W-1:0] cur_slot;
  logic [SAW-1:0]    cur_sidx;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  idx;

  // result register
  logic [SLOT_W-1:0] o_slot;
  sample_t           o_smp;
  logic              o_last;

  logic [SAW+SLOT_W-1:0] head_wide;
  logic [SAW-1:0]        head_sidx;
  logic [CNT_W-1:0]      idx_inc;
  logic [DW+CNT_W-1:0]   idx_wide;
  logic                  out_take;
  logic                  more;

  // control strobes
  logic load_cmd;
  logic load_pass;
  logic load_run;
  logic step_idx;

  assign head_wide = {{SAW{1'b0}}, head.slot};
  assign head_sidx = head_wide[SAW-1:0];
  assign idx_inc   = idx + CNT_W'(1);
  assign idx_wide  = {{DW{1'b0}}, idx_inc};
  assign out_take  = out_valid && !out_stall;
  assign more      = (cur_kind == CMD_RUN) && !o_last;

  assign out_slot     = o_slot;
  assign out_x        = o_smp.x;
  assign out_y        = o_smp.y;
  assign out_pressure = o_smp.p;
  assign run_last     = o_last;

  // sample store write port
  always_ff @(posedge clk) begin
    if (held_we) begin
      held_mem[held_waddr] <= held_wdata;
    end
  end

  // sample store read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= held_mem[rd_addr];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command and result registers
  always_ff @(posedge clk) begin
    if (load_cmd) begin
      cur_kind <= head.kind;
      cur_slot <= head.slot;
      cur_sidx <= head_sidx;
      cur_cnt  <= head.cnt;
      idx      <= '0;
    end else if (step_idx) begin
      idx <= idx_inc;
    end
    if (load_pass) begin
      o_slot <= head.slot;
      o_smp  <= head.smp;
      o_last <= 1'b1;
    end else if (load_run) begin
      o_slot <= cur_slot;
      o_smp  <= rd_data;
      o_last <= (idx_inc == cur_cnt);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = (head.kind == CMD_PASS) ? BK_OUT : BK_LOAD;
        end
      end
      BK_LOAD: state_next = BK_OUT;
      BK_OUT: begin
        if (out_take) begin
          state_next = more ? BK_LOAD : BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs and strobes
  always_comb begin
    pop       = 1'b0;
    load_cmd  = 1'b0;
    load_pass = 1'b0;
    load_run  = 1'b0;
    step_idx  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = {head_sidx, {DW{1'b0}}};
    out_valid = 1'b0;
    bk_status = '{run_done: 1'b0,
                  run_active: (state != BK_IDLE) && (cur_kind == CMD_RUN)};
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          load_cmd  = 1'b1;
          load_pass = (head.kind == CMD_PASS);
          rd_en     = (head.kind == CMD_RUN);
        end
      end
      BK_LOAD: begin
        load_run = 1'b1;
      end
      BK_OUT: begin
        out_valid = 1'b1;
        if (out_take && more) begin
          step_idx = 1'b1;
          rd_en    = 1'b1;
          rd_addr  = {cur_sidx, idx_wide[DW-1:0]};
        end
        bk_status.run_done = out_take && !more && (cur_kind == CMD_RUN);
      end
      default: out_valid = 1'b0;
    endcase
  end

endmodule

>>> sv/short_touch_sequence_dropper_top.sv
// Top level of the short touch sequence dropper: config register and part wiring.
//
// Each slot holds back new contact samples until run_length of them (read as
// 1 when zero, capped at DEPTH and MAX_RUN) have arrived; an earlier pen-up
// sample drops them silently. A full buffer is emitted as one run, oldest
// first, with run_last on its final sample, and the slot then passes samples
// straight through until a pen-up. The front part accepts a sample in FR_IDLE,
// reading its slot state, and in FR_DECIDE updates that state and pushes any
// result request; it takes no new sample until it leaves FR_DECIDE, which a
// full queue or a pending run can delay. The back part pops a pass-through
// command and then outputs it; for a run of n samples it pops the command and
// then does a memory read and an output step per result; output stalls hold it.
// A holding sample that arrives while a run is queued or draining waits in the
// front part until no run is left. The sample memory needs no clearing after
// reset; the block takes samples from the first cycle after reset.
module short_touch_sequence_dropper_top #(
  parameter int SLOTS = stsd_pkg::SLOTS_DEF,
  parameter int DEPTH = stsd_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample input channel
  input  logic                                 valid,
  output logic                                 stall,
  input  logic [stsd_pkg::SLOT_W-1:0]          slot,
  input  logic signed [stsd_pkg::COORD_W-1:0]  pos_x,
  input  logic signed [stsd_pkg::COORD_W-1:0]  pos_y,
  input  logic [stsd_pkg::COORD_W-1:0]         pressure,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [stsd_pkg::SLOT_W-1:0]          out_slot,
  output logic signed [stsd_pkg::COORD_W-1:0]  out_x,
  output logic signed [stsd_pkg::COORD_W-1:0]  out_y,
  output logic [stsd_pkg::COORD_W-1:0]         out_pressure,
  output logic                                 run_last,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import stsd_pkg::*;

  localparam int AW = slot_aw(SLOTS) + $clog2(DEPTH);
  localparam logic REG_RUN_LENGTH = 1'b0;

  logic [RUN_LEN_W-1:0] run_length;
  logic                 cfg_wr;

  logic       fr_push;
  cmd_t       push_cmd;
  logic       q_full;
  logic       q_empty;
  logic       bk_pop;
  cmd_t       q_head;
  bk_status_t bk_status;
  logic       held_we;
  logic [AW-1:0] held_waddr;
  sample_t    held_wdata;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RUN_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length <= RUN_LEN_RESET;
    end else if (cfg_wr) begin
      run_length <= pwdata[RUN_LEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_RUN_LENGTH) ? {{(32 - RUN_LEN_W){1'b0}}, run_length}
                                               : '0;

  stsd_front #(
    .SLOTS (SLOTS),
    .DEPTH (DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .valid      (valid),
    .stall      (stall),
    .slot       (slot),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pressure   (pressure),
    .run_length (run_length),
    .push       (fr_push),
    .push_cmd   (push_cmd),
    .q_full     (q_full),
    .bk_status  (bk_status),
    .held_we    (held_we),
    .held_waddr (held_waddr),
    .held_wdata (held_wdata)
  );

  stsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (fr_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (bk_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  stsd_back #(
    .SLOTS (SLOTS),
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (q_head),
    .pop          (bk_pop),
    .held_we      (held_we),
    .held_waddr   (held_waddr),
    .held_wdata   (held_wdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_slot     (out_slot),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_pressure (out_pressure),
    .run_last     (run_last),
    .bk_status    (bk_status)
  );

  // checks
`include "short_touch_sequence_dropper_top_assert.svh"

  `STSD_ASSERT_IMP(a_push_room, fr_push, !q_full, "command pushed into a full queue")
  `STSD_ASSERT_IMP(a_pop_data, bk_pop, !q_empty, "command popped from an empty queue")
  `STSD_ASSERT_IMP(a_hold_safe, held_we, !bk_status.run_active, "held write during a run")
  `STSD_ASSERT_NXT(a_run_gap, out_valid && !out_stall && !run_last, !out_valid, "run step skipped")

endmodule

>>> tb/sv/tb_short_touch_sequence_dropper_top.sv
// Testbench for the short touch sequence dropper: directed and random touch sequences.
module tb_short_touch_sequence_dropper_top;
  import stsd_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int DEPTH = DEPTH_DEF;
  localparam int THR_MAX = (DEPTH < MAX_RUN) ? DEPTH : MAX_RUN;
  localparam logic [2:0] RUN_LEN_ADDR = 3'd0;
  // cycles for a held request to settle once no result is pending
  localparam int SETTLE_CYCLES = 16;

  typedef struct {
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COORD_W-1:0]        p;
    logic                      last;
  } touch_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       valid = 1'b0;
  logic                       stall;
  logic [SLOT_W-1:0]          slot = '0;
  logic signed [COORD_W-1:0]  pos_x = '0;
  logic signed [COORD_W-1:0]  pos_y = '0;
  logic [COORD_W-1:0]         pressure = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [SLOT_W-1:0]          out_slot;
  logic signed [COORD_W-1:0]  out_x;
  logic signed [COORD_W-1:0]  out_y;
  logic [COORD_W-1:0]         out_pressure;
  logic                       run_last;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [2:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  short_touch_sequence_dropper_top #(.SLOTS(SLOTS), .DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .valid(valid), .stall(stall), .slot(slot), .pos_x(pos_x), .pos_y(pos_y),
    .pressure(pressure),
    .out_valid(out_valid), .out_stall(out_stall), .out_slot(out_slot), .out_x(out_x),
    .out_y(out_y), .out_pressure(out_pressure), .run_last(run_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // Predictor state: per-slot held samples, count and holding flag
  sample_t              held_smp [SLOTS][DEPTH];
  int                   held_cnt [SLOTS];
  logic                 holding [SLOTS];
  logic [RUN_LEN_W-1:0] run_len_reg = RUN_LEN_RESET;
  touch_result_t        pending_results [$];

  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver stall, random per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    touch_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: slot %0d x %0d y %0d pressure %0d",
               out_slot, out_x, out_y, out_pressure);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_slot !== want.slot) begin
          $error("out_slot: expected %0d, got %0d", want.slot, out_slot);
          error_count++;
        end
        if (out_x !== want.x) begin
          $error("out_x: expected %0d, got %0d", want.x, out_x);
          error_count++;
        end
        if (out_y !== want.y) begin
          $error("out_y: expected %0d, got %0d", want.y, out_y);
          error_count++;
        end
        if (out_pressure !== want.p) begin
          $error("out_pressure: expected %0d, got %0d", want.p, out_pressure);
          error_count++;
        end
        if (run_last !== want.last) begin
          $error("run_last: expected %0d, got %0d", want.last, run_last);
          error_count++;
        end
      end
    end
  end

  // Threshold is run_length saturated to 1..THR_MAX
  function automatic int eff_threshold();
    int n;
    n = run_len_reg;
    if (n < 1) n = 1;
    if (n > THR_MAX) n = THR_MAX;
    return n;
  endfunction

  // Work out the results one accepted sample causes
  function automatic void predict_sample(input logic [SLOT_W-1:0] s,
                                         input logic [COORD_W-1:0] x, y, p);
    touch_result_t r;
    sample_t       smp;
    int            thr;
    int            cnt;
    smp.x = x;
    smp.y = y;
    smp.p = p;
    if (!holding[s]) begin
      if (p == '0) holding[s] = 1'b1;
      r = '{slot: s, x: x, y: y, p: p, last: 1'b1};
      pending_results.push_back(r);
      return;
    end
    thr = eff_threshold();
    cnt = held_cnt[s];
    // early pen-up drops the touch
    if (p == '0 && cnt < thr) begin
      held_cnt[s] = 0;
      return;
    end
    if (cnt >= DEPTH) cnt = DEPTH - 1;
    held_smp[s][cnt] = smp;
    cnt++;
    if (cnt < thr) begin
      held_cnt[s] = cnt;
      return;
    end
    // buffer full: emit the run oldest first
    for (int i = 0; i < cnt; i++) begin
      r = '{slot: s, x: held_smp[s][i].x, y: held_smp[s][i].y, p: held_smp[s][i].p,
            last: (i + 1 == cnt)};
      pending_results.push_back(r);
    end
    held_cnt[s] = 0;
    holding[s] = 1'b0;
  endfunction

  // Send one sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic [SLOT_W-1:0] s, input logic [COORD_W-1:0] x, y, p);
    if ($urandom_range(99) < send_idle_pct) begin
      valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    valid <= 1'b1;
    slot <= s;
    pos_x <= x;
    pos_y <= y;
    pressure <= p;
    do @(posedge clk); while (stall);
    predict_sample(s, x, y, p);
  endtask

  // Drop valid and wait until nothing is pending and the block has settled
  task automatic wait_idle();
    valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Read run_length back and compare
  task automatic check_run_length(input logic [RUN_LEN_W-1:0] want);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= RUN_LEN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(32-RUN_LEN_W){1'b0}}, want}) begin
      $error("prdata: expected %0d, got %0d", want, prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write run_length through the config port, then read it back
  task automatic write_run_length(input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RUN_LEN_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    run_len_reg = data[RUN_LEN_W-1:0];
    check_run_length(data[RUN_LEN_W-1:0]);
  endtask

  // Reset threshold of 5, field extremes, pass-through and pen-up pass
  task automatic test_reset_threshold();
    check_run_length(RUN_LEN_RESET);
    send_sample(4'd0, 16'h8000, 16'h7fff, 16'hffff);
    send_sample(4'd0, 16'h7fff, 16'h8000, 16'h0001);
    send_sample(4'd0, 16'h0000, 16'hffff, 16'h8000);
    send_sample(4'd0, 16'hffff, 16'h0000, 16'h7fff);
    send_sample(4'd0, 16'h5555, 16'haaaa, 16'haaaa);
    send_sample(4'd0, 16'haaaa, 16'h5555, 16'h5555);
    send_sample(4'd0, 16'h1234, 16'h8765, 16'h0000);
  endtask

  // Short touch dropped, pen-up on an empty slot, interleaved slot
  task automatic test_short_touch_dropped();
    send_sample(4'd15, 16'h0101, 16'h0202, 16'h0010);
    send_sample(4'd8, 16'h0303, 16'h0404, 16'h0020);
    send_sample(4'd15, 16'h0505, 16'h0606, 16'h0030);
    send_sample(4'd15, 16'h0707, 16'h0808, 16'h0000);
    send_sample(4'd15, 16'h0909, 16'h0a0a, 16'h0000);
  endtask

  // run_length of zero acts as one
  task automatic test_zero_run_length();
    wait_idle();
    write_run_length(32'd0);
    send_sample(4'd7, 16'hf00f, 16'h0ff0, 16'h0400);
    send_sample(4'd7, 16'h0ff0, 16'hf00f, 16'h0000);
    send_sample(4'd7, 16'h1111, 16'h2222, 16'h0000);
  endtask

  // Threshold lowered below the held count: a pen-up completes the run
  task automatic test_threshold_lowered();
    wait_idle();
    write_run_length(32'd10);
    send_sample(4'd3, 16'h0011, 16'h0022, 16'h0100);
    send_sample(4'd3, 16'h0033, 16'h0044, 16'h0200);
    send_sample(4'd3, 16'h0055, 16'h0066, 16'h0300);
    send_sample(4'd3, 16'h0077, 16'h0088, 16'h0400);
    wait_idle();
    write_run_length(32'd2);
    send_sample(4'd3, 16'h0099, 16'h00aa, 16'h0000);
    send_sample(4'd3, 16'h00bb, 16'h00cc, 16'h0500);
    send_sample(4'd3, 16'h00dd, 16'h00ee, 16'h0000);
  endtask

  // Random touches on a pool of slots, plus some noise requests
  task automatic test_random_touches(input int idle_pct, stall_pct, run_len, n_pool, n_items);
    int                target [SLOTS];
    int                sofar [SLOTS];
    logic [SLOT_W-1:0] pool [4];
    logic [SLOT_W-1:0] s;
    logic [COORD_W-1:0] p;
    int                thr;
    wait_idle();
    write_run_length(run_len);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    thr = (run_len < 1) ? 1 : ((run_len > THR_MAX) ? THR_MAX : run_len);
    for (int i = 0; i < SLOTS; i++) begin
      sofar[i] = 0;
      target[i] = $urandom_range(1) ? $urandom_range(thr, thr + 2) : $urandom_range(0, thr - 1);
    end
    for (int i = 0; i < 4; i++) pool[i] = SLOT_W'($urandom_range(SLOTS - 1));
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(9) == 0) begin
        // noise: any slot, any pressure
        s = SLOT_W'($urandom_range(SLOTS - 1));
        p = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
      end else begin
        s = pool[$urandom_range(n_pool - 1)];
        if (sofar[s] >= target[s]) begin
          p = 16'h0000;
          sofar[s] = 0;
          target[s] = $urandom_range(1) ? $urandom_range(thr, thr + 2)
                                        : $urandom_range(0, thr - 1);
        end else begin
          p = COORD_W'($urandom_range(1, 65535));
          sofar[s]++;
        end
      end
      send_sample(s, 16'($urandom), 16'($urandom), p);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      held_cnt[i] = 0;
      holding[i] = 1'b1;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_threshold();
    test_short_touch_dropped();
    test_zero_run_length();
    test_threshold_lowered();
    test_random_touches(0, 0, 5, 3, 35);
    test_random_touches(54, 0, 1, 3, 30);
    test_random_touches(0, 54, 63, 1, 40);
    test_random_touches(11, 11, 3, 4, 30);

    wait_idle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
